// ----- hw/rtl/hswt_pkg.sv -----
`default_nettype none
package hswt_pkg;

  typedef enum logic [2:0] {
    MODE_TEXT   = 3'd0,
    MODE_ENTITY = 3'd1,
    MODE_TNAME  = 3'd2,
    MODE_TAG    = 3'd3,
    MODE_RAW    = 3'd4,
    MODE_RAWLT  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_SHORT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  token_char;
    logic [7:0]  char_index;
    logic [7:0]  token_length;
    logic [15:0] word_position;
  } result_t;

  localparam int NumRaw = 4;
  localparam logic [7:0] CaseBit = 8'h20;
  localparam logic [7:0] MaxLen = 8'd255;
  localparam logic [15:0] MaxPos = 16'hFFFF;
  localparam logic [7:0] ChAmp = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLt = 8'h3C;
  localparam logic [7:0] ChGt = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash = 8'h2D;

  // raw-text tag names: script, style, code, template
  localparam logic [3:0] RawLen [NumRaw] = '{4'd6, 4'd5, 4'd4, 4'd8};

  // first character of each name sits in the lowest byte
  function automatic logic [7:0] raw_char(input logic [1:0] name, input logic [2:0] pos);
    logic [63:0] s;
    case (name)
      2'd0:    s = {16'h0000, "tpircs"};
      2'd1:    s = {24'h000000, "elyts"};
      2'd2:    s = {32'h00000000, "edoc"};
      default: s = "etalpmet";
    endcase
    raw_char = s[{pos, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/html_strip_word_tokenizer.sv -----
`default_nettype none
// channel        dir  payload
// s_axis         in   tdata = text_byte[7:0], tlast = doc_end
// m_axis         out  tdata = token_char, char_index, token_length, word_position; tuser = kind
// min_token_len  in   cfg_wr_en / cfg_wr_data, written any cycle
//
// One byte per cycle while s_axis_tready is high: the parser state updates in the cycle
// of acceptance and the result is registered in the output register, or in the skid register while m_axis is stalled.
// A one-entry skid register keeps s_axis_tready high for one extra result while
// m_axis is stalled; tready drops only when the skid entry is full.
// rst is synchronous, active high; it clears the parser, counters, valids and
// sets min_token_length to 1.
module html_strip_word_tokenizer
  import hswt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // doc_end
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] token_char, [15:8] char_index, [23:16] token_length, [39:24] word_position
  output      logic [39:0] m_axis_tdata,
  output      logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  logic [7:0]  min_len;
  mode_t       mode, mode_next;
  logic [3:0]  name_cnt, name_cnt_next;
  logic [3:0]  cands, cands_next;
  logic [7:0]  tok_len, tok_len_next;
  logic [15:0] acc_cnt, acc_cnt_next;

  result_t res;
  logic    res_v;
  result_t out_r, skid;
  logic    out_v, skid_v;

  logic       acc;
  logic [7:0] c;
  logic       is_word;
  logic       drain;

  assign s_axis_tready = !skid_v;
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign drain = !out_v || m_axis_tready;
  assign c     = s_axis_tdata | CaseBit;
  assign is_word = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || c == ChDash;

  // next state
  always_comb begin
    logic [3:0] live;
    logic       hit;
    mode_next     = mode;
    name_cnt_next = name_cnt;
    cands_next    = cands;
    tok_len_next  = tok_len;
    acc_cnt_next  = acc_cnt;
    live = '0;
    hit  = 1'b0;
    for (int i = 0; i < NumRaw; i++) begin
      if (cands[i] && name_cnt < RawLen[i] &&
          raw_char(2'(i), name_cnt[2:0]) == c) begin
        live[i] = 1'b1;
        if (name_cnt + 4'd1 == RawLen[i]) hit = 1'b1;
      end
    end
    if (s_axis_tlast) begin
      mode_next     = MODE_TEXT;
      name_cnt_next = '0;
      cands_next    = '1;
      tok_len_next  = '0;
      acc_cnt_next  = '0;
    end else begin
      case (mode)
        MODE_ENTITY: if (c == ChSemi) mode_next = MODE_TEXT;
        MODE_TNAME: begin
          if (hit || live == '0) begin
            name_cnt_next = '0;
            cands_next    = '1;
            mode_next     = hit ? MODE_RAW : ((c == ChGt) ? MODE_TEXT : MODE_TAG);
          end else begin
            cands_next    = live;
            name_cnt_next = name_cnt + 4'd1;
          end
        end
        MODE_TAG:   if (c == ChGt) mode_next = MODE_TEXT;
        MODE_RAW:   if (c == ChLt) mode_next = MODE_RAWLT;
        MODE_RAWLT: begin
          if (c == ChSlash) mode_next = MODE_TAG;
          else if (c != ChLt) mode_next = MODE_RAW;
        end
        default: begin
          mode_next = MODE_TEXT;
          if (is_word) begin
            if (tok_len != MaxLen) tok_len_next = tok_len + 8'd1;
          end else begin
            if (tok_len != '0 && tok_len >= min_len && acc_cnt != MaxPos)
              acc_cnt_next = acc_cnt + 16'd1;
            tok_len_next = '0;
            if (c == ChAmp) begin
              mode_next = MODE_ENTITY;
            end else if (c == ChLt) begin
              mode_next     = MODE_TNAME;
              name_cnt_next = '0;
              cands_next    = '1;
            end
          end
        end
      endcase
    end
  end

  // result of the current request
  always_comb begin
    logic ending;
    res    = '0;
    res_v  = 1'b0;
    ending = s_axis_tlast || ((mode == MODE_TEXT) && !is_word);
    if (!s_axis_tlast && mode == MODE_TEXT && is_word && tok_len != MaxLen) begin
      res_v          = 1'b1;
      res.kind       = KIND_CHAR;
      res.token_char = c;
      res.char_index = tok_len;
    end else if (ending && tok_len != '0) begin
      res_v            = 1'b1;
      res.token_length = tok_len;
      if (tok_len < min_len) begin
        res.kind = KIND_SHORT;
      end else begin
        res.kind          = KIND_ACCEPT;
        res.word_position = acc_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len  <= 8'd1;
      mode     <= MODE_TEXT;
      name_cnt <= '0;
      cands    <= '1;
      tok_len  <= '0;
      acc_cnt  <= '0;
      out_v    <= 1'b0;
      skid_v   <= 1'b0;
    end else begin
      if (cfg_wr_en) min_len <= cfg_wr_data;
      if (acc) begin
        mode     <= mode_next;
        name_cnt <= name_cnt_next;
        cands    <= cands_next;
        tok_len  <= tok_len_next;
        acc_cnt  <= acc_cnt_next;
      end
      if (drain) begin
        if (skid_v) begin
          out_v  <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          out_v <= acc && res_v;
        end
      end else if (acc && res_v) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_r <= skid_v ? skid : res;
    end else if (acc && res_v) begin
      skid <= res;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = out_r.kind;
  assign m_axis_tdata  = {out_r.word_position, out_r.token_length,
                          out_r.char_index, out_r.token_char};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v) else $error("skid entry held without output entry");

  a_markup_no_token: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_TEXT |-> tok_len == '0) else $error("open token inside markup");

  a_name_cnt_range: assert property (@(posedge clk) disable iff (rst)
    name_cnt <= 4'd7) else $error("tag name counter out of range");

  a_char_fields: assert property (@(posedge clk) disable iff (rst)
    out_v && out_r.kind == KIND_CHAR |-> out_r.token_length == '0 &&
    out_r.word_position == '0) else $error("character result carries end fields");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_v && out_r.kind != KIND_CHAR |-> out_r.token_length != '0 &&
    out_r.token_char == '0) else $error("end marker with bad fields");

endmodule
`default_nettype wire

// ----- tb/sv/tb_html_strip_word_tokenizer.sv -----
module tb_html_strip_word_tokenizer
  import hswt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 4;
  localparam int MaxPrinted = 50;

  // Expected-result store plus a bit-level predictor of the tokenizer.
  class token_scoreboard;
    mode_t       mode;
    logic [3:0]  name_cnt;
    logic [3:0]  name_live;
    logic [7:0]  tok_len;
    logic [15:0] word_cnt;
    logic [7:0]  min_len;
    result_t     expected_q[$];
    int          errors;
    string       raw_tags[4];

    function new();
      raw_tags = '{"script", "style", "code", "template"};
      min_len  = 8'd1;
      tok_len  = '0;
      word_cnt = '0;
      errors   = 0;
      restart_parser();
    endfunction

    function void restart_parser();
      mode      = MODE_TEXT;
      name_cnt  = '0;
      name_live = 4'hF;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void expect_result(kind_t k, logic [7:0] ch, logic [7:0] idx,
                                logic [7:0] len, logic [15:0] pos);
      result_t r;
      r.kind          = k;
      r.token_char    = ch;
      r.char_index    = idx;
      r.token_length  = len;
      r.word_position = pos;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void close_token();
      if (tok_len != 0) begin
        if (tok_len < min_len) begin
          expect_result(KIND_SHORT, '0, '0, tok_len, '0);
        end else begin
          expect_result(KIND_ACCEPT, '0, '0, tok_len, word_cnt);
          if (word_cnt != MaxPos) word_cnt++;
        end
      end
      tok_len = '0;
    endfunction

    // Called for every accepted input request.
    function void note_request(logic [7:0] text_byte, logic doc_end);
      logic [7:0] c;
      logic       is_word;
      logic [3:0] live;
      logic       hit;
      int         k;
      if (doc_end) begin
        close_token();
        restart_parser();
        word_cnt = '0;
        return;
      end
      c = text_byte | CaseBit;
      is_word = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || c == ChDash;
      case (mode)
        MODE_ENTITY: begin
          if (c == ChSemi) mode = MODE_TEXT;
        end
        MODE_TNAME: begin
          k = name_cnt;
          live = '0;
          hit = 1'b0;
          for (int i = 0; i < 4; i++) begin
            if (name_live[i] && k < raw_tags[i].len() && raw_tags[i][k] == c) begin
              live[i] = 1'b1;
              if (k + 1 == raw_tags[i].len()) hit = 1'b1;
            end
          end
          if (hit) begin
            restart_parser();
            mode = MODE_RAW;
          end else if (live == 0) begin
            restart_parser();
            mode = (c == ChGt) ? MODE_TEXT : MODE_TAG;
          end else begin
            name_live = live;
            name_cnt = name_cnt + 4'd1;
          end
        end
        MODE_TAG: begin
          if (c == ChGt) mode = MODE_TEXT;
        end
        MODE_RAW: begin
          if (c == ChLt) mode = MODE_RAWLT;
        end
        MODE_RAWLT: begin
          if (c == ChSlash) mode = MODE_TAG;
          else if (c != ChLt) mode = MODE_RAW;
        end
        default: begin
          mode = MODE_TEXT;
          if (is_word) begin
            // characters past the cap are dropped silently
            if (tok_len != MaxLen) begin
              expect_result(KIND_CHAR, c, tok_len, '0, '0);
              tok_len++;
            end
          end else begin
            close_token();
            if (c == ChAmp) begin
              mode = MODE_ENTITY;
            end else if (c == ChLt) begin
              restart_parser();
              mode = MODE_TNAME;
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind_bits, logic [39:0] data);
      result_t exp;
      logic [7:0]  ch;
      logic [7:0]  idx;
      logic [7:0]  len;
      logic [15:0] pos;
      ch  = data[7:0];
      idx = data[15:8];
      len = data[23:16];
      pos = data[39:24];
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d tdata %h", kind_bits, data));
        return;
      end
      exp = expected_q.pop_front();
      if (kind_bits !== exp.kind)
        report($sformatf("kind %0d, expected %0d", kind_bits, exp.kind));
      if (ch !== exp.token_char)
        report($sformatf("token_char %h, expected %h", ch, exp.token_char));
      if (idx !== exp.char_index)
        report($sformatf("char_index %0d, expected %0d", idx, exp.char_index));
      if (len !== exp.token_length)
        report($sformatf("token_length %0d, expected %0d", len, exp.token_length));
      if (pos !== exp.word_position)
        report($sformatf("word_position %0d, expected %0d", pos, exp.word_position));
    endtask
  endclass

  typedef struct packed {
    logic [7:0] text_byte;
    logic       doc_end;
  } text_req_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] text_byte
  logic        s_axis_tlast;    // doc_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] token_char, [15:8] char_index, [23:16] token_length, [39:24] word_position
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;    // [1:0] kind
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  token_scoreboard sb;
  text_req_t       text_q[$];
  int              hold_cycles;
  int              cycles;

  html_strip_word_tokenizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata, s_axis_tlast);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // receiver: own stall pattern, long hold-offs on request
  initial begin
    int pattern;
    int left;
    pattern = 0;
    left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        if (left == 0) begin
          pattern = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (pattern)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
          2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready <= left[1];
        endcase
      end
    end
  end

  function void push_byte(logic [7:0] b);
    text_req_t r;
    r.text_byte = b;
    r.doc_end   = 1'b0;
    text_q.insert(text_q.size(), r);
  endfunction

  function void push_doc_end();
    text_req_t r;
    r.text_byte = 8'($urandom_range(0, 255));
    r.doc_end   = 1'b1;
    text_q.insert(text_q.size(), r);
  endfunction

  function void push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endfunction

  function logic [7:0] random_case(logic [7:0] ch);
    return $urandom_range(0, 1) ? (ch & ~CaseBit) : ch;
  endfunction

  function logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 39);
    if (r < 26) return random_case(8'("a" + r));
    if (r < 36) return 8'("0" + r - 26);
    if (r < 38) return ChDash;
    if (r == 38) return 8'h0D;   // control byte that folds onto '-'
    return 8'("0" + $urandom_range(0, 9)) & ~CaseBit;
  endfunction

  function void push_separator();
    case ($urandom_range(0, 6))
      0:       push_byte(",");
      1:       push_byte(".");
      2:       push_byte(8'h0A);
      3:       push_byte("_");
      4:       push_byte(8'h00);
      5:       push_byte(8'h09);
      default: push_byte(" ");
    endcase
  endfunction

  function void push_word(int long_pct);
    int len;
    len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(240, 300) : $urandom_range(1, 9);
    repeat (len) push_byte(word_char());
    push_separator();
  endfunction

  function void push_tag();
    string names[10];
    names = '{"p", "div", "b", "scr", "sty", "co", "templat", "s", "t", ""};
    push_byte("<");
    if ($urandom_range(0, 3) == 0) push_byte("/");
    push_text(names[$urandom_range(0, 9)]);
    if ($urandom_range(0, 1)) push_text(" id=x-1");
    push_byte(">");
  endfunction

  function void push_raw_block(int long_pct);
    string names[4];
    string n;
    names = '{"script", "style", "code", "template"};
    n = names[$urandom_range(0, 3)];
    push_byte("<");
    foreach (n[i]) push_byte(random_case(n[i]));
    if ($urandom_range(0, 1)) push_text(" type=a>");
    else push_byte(">");
    repeat ($urandom_range(1, 3)) begin
      push_word(long_pct);
      case ($urandom_range(0, 3))
        0:       push_text("a<b");
        1:       push_text("<<x");
        default: ;
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      push_doc_end();   // document ends inside raw text
    end else begin
      push_text("</");
      push_text(n);
      push_byte(">");
    end
  endfunction

  function void push_entity();
    push_byte("&");
    repeat ($urandom_range(1, 5)) push_byte(8'("a" + $urandom_range(0, 25)));
    if ($urandom_range(0, 9) != 0) push_byte(";");
  endfunction

  function void build_random_text(int n_items, int long_pct);
    n_items += text_q.size();
    while (text_q.size() < n_items) begin
      case ($urandom_range(0, 19))
        9, 10:  push_tag();
        11, 12: push_raw_block(long_pct);
        13:     push_entity();
        14, 15: repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        16:     push_doc_end();
        default: push_word(long_pct);
      endcase
    end
    push_doc_end();
  endfunction

  task send_request(text_req_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.text_byte;
    s_axis_tlast  <= r.doc_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task drive_text(bit no_gaps);
    int burst;
    while (text_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && text_q.size() != 0) begin
        send_request(text_q.pop_front());
        burst--;
      end
      if (!no_gaps && text_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Items that end no token leave no trace, so settle past the last result and check again that none is pending.
  task wait_idle();
    @(posedge clk);
    do begin
      while (sb.pending() != 0) @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  task write_min_length(logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.min_len = value;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_cycles = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: case folding, control bytes, entity, empty tag, raw tag, end inside a tag
    push_text("Az_9-");
    push_byte(8'h0D);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("x&a;y<>q<STYLE>s</b>t<p");
    push_doc_end();
    drive_text(1'b0);
    wait_idle();

    write_min_length(8'd0);
    build_random_text(100, 0);
    drive_text(1'b0);
    wait_idle();

    // every word is long here, so tokens run into the length cap
    write_min_length(8'd255);
    build_random_text(60, 100);
    drive_text(1'b0);
    wait_idle();

    // receiver holds off while the sender keeps pushing
    write_min_length(8'd3);
    build_random_text(80, 0);
    hold_cycles = 300;
    drive_text(1'b1);
    wait_idle();

    write_min_length(8'($urandom_range(2, 8)));
    build_random_text(60, 0);
    drive_text(1'b1);
    wait_idle();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
